// ===== rtl/gdod_pkg.sv =====
`timescale 1ns / 1ps

package gdod_pkg;

  // Widths of the serial day number and of the shared divider
  localparam int SERIAL_W = 23;
  localparam int DIVR_W   = 18;
  localparam int QUO_W    = 9;

  // Divisors loaded into the repeated-subtraction divider
  localparam logic [DIVR_W-1:0] DIV_ERA   = 18'd146097;
  localparam logic [DIVR_W-1:0] DIV_Y400  = 18'd400;
  localparam logic [DIVR_W-1:0] DIV_4YR   = 18'd1460;
  localparam logic [DIVR_W-1:0] DIV_YEAR  = 18'd365;

  localparam logic [14:0] YEAR_BIAS = 15'd4000;

  // Serial numbers of 0001-01-01 and 9999-12-31
  localparam logic [SERIAL_W-1:0] SERIAL_LO = 23'd1461276;
  localparam logic [SERIAL_W-1:0] SERIAL_HI = 23'd5113334;

  localparam logic FUNC_SHIFT = 1'b0;
  localparam logic FUNC_DIFF  = 1'b1;

  localparam logic [1:0] ORD_EARLIER = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  typedef struct packed {
    logic load;     // capture input item
    logic sel_b;    // work on the second date
    logic prep;     // clamp month, start year/400 division
    logic div_run;  // advance the divider
    logic mul;      // register serial products, collect bad flag
    logic sum;      // form serial day number
    logic shift;    // add offset, clamp, start era division
    logic doe;      // hold era and day of era, start /1460
    logic tload;    // start day-of-era / 365
    logic ymul;     // register year products
    logic fin;      // write shifted-date result
    logic diff;     // write difference result
  } cmd_t;

  typedef struct packed {
    logic func;
    logic div_fin;
  } status_t;

  // Length of month m (1..12), February without leap day
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // First day of month index mp in a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Whole centuries in a year of era (0..399)
  function automatic logic [1:0] century_of(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300)      c = 2'd3;
    else if (yoe >= 9'd200) c = 2'd2;
    else if (yoe >= 9'd100) c = 2'd1;
    else                    c = 2'd0;
    return c;
  endfunction

endpackage

// ===== rtl/gdod_csub.sv =====
`timescale 1ns / 1ps

// Divide by a loaded constant, one subtraction per cycle while run is high.
module gdod_csub (
  input  logic                             clk,
  input  logic                             load,
  input  logic [gdod_pkg::SERIAL_W-1:0]    load_num,
  input  logic [gdod_pkg::DIVR_W-1:0]      load_div,
  input  logic                             run,
  output logic [gdod_pkg::SERIAL_W-1:0]    rem,
  output logic [gdod_pkg::QUO_W-1:0]       quo,
  output logic                             fin
);

  logic [gdod_pkg::DIVR_W-1:0] divisor;
  logic [gdod_pkg::SERIAL_W-1:0] div_ext;

  assign div_ext = {{(gdod_pkg::SERIAL_W - gdod_pkg::DIVR_W){1'b0}}, divisor};
  assign fin     = rem < div_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      rem     <= load_num;
      quo     <= '0;
      divisor <= load_div;
    end else if (run && !fin) begin
      rem <= rem - div_ext;
      quo <= quo + 1'b1;
    end
  end

endmodule

// ===== rtl/gdod_datapath.sv =====
`timescale 1ns / 1ps

module gdod_datapath (
  input  logic                 clk,
  input  gdod_pkg::cmd_t       cmd,
  output gdod_pkg::status_t    status,
  input  logic                 func,
  input  logic [13:0]          year,
  input  logic [3:0]           month,
  input  logic [4:0]           day,
  input  logic signed [20:0]   offset,
  input  logic [13:0]          other_year,
  input  logic [3:0]           other_month,
  input  logic [4:0]           other_day,
  output logic [13:0]          res_year,
  output logic [3:0]           res_month,
  output logic [4:0]           res_day,
  output logic signed [22:0]   day_difference,
  output logic [1:0]           ordering,
  output logic                 invalid_date,
  output logic                 year_overflow
);

  localparam int SW = gdod_pkg::SERIAL_W;

  // Captured item
  logic        func_r;
  logic [13:0] ya, yb;
  logic [3:0]  ma, mb;
  logic [4:0]  da, db;
  logic [20:0] off_r;

  // Divider
  logic                         dv_load;
  logic [SW-1:0]                dv_num;
  logic [gdod_pkg::DIVR_W-1:0]  dv_div;
  logic [SW-1:0]                dv_rem;
  logic [gdod_pkg::QUO_W-1:0]   dv_quo;
  logic                         dv_fin;

  // Date to serial
  logic [13:0] y_s;
  logic [3:0]  m_s, m_c, mp_c;
  logic [4:0]  d_s, d_c, len;
  logic        bad_m, bad_d, leap, early;
  logic [14:0] yy;
  logic [8:0]  yoe_c, r400, doy_c;
  logic [9:0]  tail_sum_c;
  logic [SW-1:0] prod_e;
  logic [17:0] prod_yd;
  logic [9:0]  tail_sum;
  logic [SW-1:0] serial_a, serial_b;
  logic        bad_acc;

  // Serial to date
  logic signed [24:0] s_sum;
  logic [SW-1:0] z_c;
  logic        ovf_c, ovf_r;
  logic [5:0]  era_r;
  logic [17:0] doe_r, t_c;
  logic [2:0]  c4y;
  logic [8:0]  yoe_r;
  logic [17:0] prod_y;
  logic [13:0] era400;
  logic [17:0] yd_f;
  logic [8:0]  doy_f;
  logic [3:0]  mp_f, mo_f;
  logic [4:0]  dd_f;
  logic [14:0] yr_f;

  // Difference
  logic signed [23:0] d24;

  gdod_csub u_csub (
    .clk      (clk),
    .load     (dv_load),
    .load_num (dv_num),
    .load_div (dv_div),
    .run      (cmd.div_run),
    .rem      (dv_rem),
    .quo      (dv_quo),
    .fin      (dv_fin)
  );

  assign status.func    = func_r;
  assign status.div_fin = dv_fin;

  // Clamp the selected date and derive its day of a March-based year
  always_comb begin
    y_s   = cmd.sel_b ? yb : ya;
    m_s   = cmd.sel_b ? mb : ma;
    d_s   = cmd.sel_b ? db : da;
    bad_m = (m_s == 4'd0) || (m_s > 4'd12);
    if (m_s == 4'd0)      m_c = 4'd1;
    else if (m_s > 4'd12) m_c = 4'd12;
    else                  m_c = m_s;
    early = (m_c <= 4'd2);
    yy    = {1'b0, y_s} + gdod_pkg::YEAR_BIAS - {14'd0, early};
    yoe_c = dv_rem[8:0];
    // year mod 400 recovered from the year of era
    if (early) r400 = (yoe_c == 9'd399) ? 9'd0 : yoe_c + 9'd1;
    else       r400 = yoe_c;
    leap  = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200)
            && (r400 != 9'd300);
    len   = ((m_c == 4'd2) && leap) ? 5'd29 : gdod_pkg::month_len(m_c);
    bad_d = (d_s == 5'd0) || (d_s > len);
    if (d_s == 5'd0)     d_c = 5'd1;
    else if (d_s > len)  d_c = len;
    else                 d_c = d_s;
    mp_c  = early ? m_c + 4'd9 : m_c - 4'd3;
    doy_c = gdod_pkg::month_start(mp_c) + {4'd0, d_c} - 9'd1;
    tail_sum_c = {3'd0, yoe_c[8:2]} - {8'd0, gdod_pkg::century_of(yoe_c)}
                 + {1'b0, doy_c};
  end

  // Offset shift with range clamp
  always_comb begin
    s_sum = $signed({2'b00, serial_a}) + $signed({{4{off_r[20]}}, off_r});
    ovf_c = 1'b0;
    z_c   = s_sum[SW-1:0];
    if (s_sum < $signed({2'b00, gdod_pkg::SERIAL_LO})) begin
      z_c   = gdod_pkg::SERIAL_LO;
      ovf_c = 1'b1;
    end else if (s_sum > $signed({2'b00, gdod_pkg::SERIAL_HI})) begin
      z_c   = gdod_pkg::SERIAL_HI;
      ovf_c = 1'b1;
    end
  end

  // Leap-cycle correction before the divide by 365
  always_comb begin
    if (doe_r >= 18'd146096)      c4y = 3'd4;
    else if (doe_r >= 18'd109572) c4y = 3'd3;
    else if (doe_r >= 18'd73048)  c4y = 3'd2;
    else if (doe_r >= 18'd36524)  c4y = 3'd1;
    else                          c4y = 3'd0;
    t_c = doe_r - {9'd0, dv_quo} + {15'd0, c4y} - {17'd0, doe_r == 18'd146096};
  end

  always_comb begin
    dv_load = cmd.prep | cmd.shift | cmd.doe | cmd.tload;
    dv_num  = '0;
    dv_div  = gdod_pkg::DIV_Y400;
    if (cmd.prep) begin
      dv_num = {8'd0, yy};
      dv_div = gdod_pkg::DIV_Y400;
    end else if (cmd.shift) begin
      dv_num = z_c;
      dv_div = gdod_pkg::DIV_ERA;
    end else if (cmd.doe) begin
      dv_num = {5'd0, dv_rem[17:0]};
      dv_div = gdod_pkg::DIV_4YR;
    end else if (cmd.tload) begin
      dv_num = {5'd0, t_c};
      dv_div = gdod_pkg::DIV_YEAR;
    end
  end

  // Split the day of era into year, month and day
  always_comb begin
    yd_f  = prod_y + {11'd0, yoe_r[8:2]} - {16'd0, gdod_pkg::century_of(yoe_r)};
    doy_f = 9'(doe_r - yd_f);
    mp_f  = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (gdod_pkg::month_start(4'(i)) <= doy_f) mp_f = 4'(i);
    end
    dd_f = 5'(doy_f - gdod_pkg::month_start(mp_f) + 9'd1);
    mo_f = (mp_f < 4'd10) ? mp_f + 4'd3 : mp_f - 4'd9;
    yr_f = {1'b0, era400} + {6'd0, yoe_r} + {14'd0, mo_f <= 4'd2}
           - gdod_pkg::YEAR_BIAS;
  end

  assign d24 = $signed({1'b0, serial_a}) - $signed({1'b0, serial_b});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      ya      <= year;
      ma      <= month;
      da      <= day;
      off_r   <= offset;
      yb      <= other_year;
      mb      <= other_month;
      db      <= other_day;
      bad_acc <= 1'b0;
    end
    if (cmd.mul) begin
      prod_e   <= {{(SW - 6){1'b0}}, dv_quo[5:0]}
                  * {{(SW - gdod_pkg::DIVR_W){1'b0}}, gdod_pkg::DIV_ERA};
      prod_yd  <= {9'd0, yoe_c} * 18'd365;
      tail_sum <= tail_sum_c;
      bad_acc  <= bad_acc | bad_m | bad_d;
    end
    if (cmd.sum) begin
      if (cmd.sel_b) serial_b <= prod_e + {5'd0, prod_yd} + {13'd0, tail_sum};
      else           serial_a <= prod_e + {5'd0, prod_yd} + {13'd0, tail_sum};
    end
    if (cmd.shift) begin
      ovf_r <= ovf_c;
    end
    if (cmd.doe) begin
      era_r <= dv_quo[5:0];
      doe_r <= dv_rem[17:0];
    end
    if (cmd.ymul) begin
      yoe_r  <= dv_quo;
      prod_y <= {9'd0, dv_quo} * 18'd365;
      era400 <= {8'd0, era_r} * 14'd400;
    end
    if (cmd.fin) begin
      res_year       <= yr_f[13:0];
      res_month      <= mo_f;
      res_day        <= dd_f;
      day_difference <= '0;
      ordering       <= gdod_pkg::ORD_EARLIER;
      invalid_date   <= bad_acc;
      year_overflow  <= ovf_r;
    end
    if (cmd.diff) begin
      res_year  <= '0;
      res_month <= '0;
      res_day   <= '0;
      if (d24 < 0)       ordering <= gdod_pkg::ORD_EARLIER;
      else if (d24 == 0) ordering <= gdod_pkg::ORD_EQUAL;
      else               ordering <= gdod_pkg::ORD_LATER;
      // saturate to the 23-bit signed range
      if (d24[23] != d24[22]) day_difference <= d24[23] ? 23'h400000 : 23'h3FFFFF;
      else                    day_difference <= d24[22:0];
      invalid_date  <= bad_acc;
      year_overflow <= 1'b0;
    end
  end

endmodule

// ===== rtl/gdod_ctrl.sv =====
`timescale 1ns / 1ps

module gdod_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  gdod_pkg::status_t  status,
  output gdod_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP_A, S_DIV_A, S_MUL_A, S_SUM_A,
    S_PREP_B, S_DIV_B, S_MUL_B, S_SUM_B, S_DIFF,
    S_SHIFT, S_DIV_ERA, S_DOE, S_DIV_4YR, S_TLOAD, S_DIV_YOE, S_YMUL, S_FIN
  } state_t;

  state_t state;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == S_IDLE) && start;
    cmd.sel_b   = (state == S_PREP_B) || (state == S_DIV_B) || (state == S_MUL_B)
                  || (state == S_SUM_B);
    cmd.prep    = (state == S_PREP_A) || (state == S_PREP_B);
    cmd.div_run = (state == S_DIV_A) || (state == S_DIV_B) || (state == S_DIV_ERA)
                  || (state == S_DIV_4YR) || (state == S_DIV_YOE);
    cmd.mul     = (state == S_MUL_A) || (state == S_MUL_B);
    cmd.sum     = (state == S_SUM_A) || (state == S_SUM_B);
    cmd.shift   = (state == S_SHIFT);
    cmd.doe     = (state == S_DOE);
    cmd.tload   = (state == S_TLOAD);
    cmd.ymul    = (state == S_YMUL);
    cmd.fin     = (state == S_FIN);
    cmd.diff    = (state == S_DIFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_PREP_A;
            busy  <= 1'b1;
          end
        end
        S_PREP_A:  state <= S_DIV_A;
        S_DIV_A:   if (status.div_fin) state <= S_MUL_A;
        S_MUL_A:   state <= S_SUM_A;
        S_SUM_A:   state <= (status.func == gdod_pkg::FUNC_DIFF) ? S_PREP_B : S_SHIFT;
        S_PREP_B:  state <= S_DIV_B;
        S_DIV_B:   if (status.div_fin) state <= S_MUL_B;
        S_MUL_B:   state <= S_SUM_B;
        S_SUM_B:   state <= S_DIFF;
        S_SHIFT:   state <= S_DIV_ERA;
        S_DIV_ERA: if (status.div_fin) state <= S_DOE;
        S_DOE:     state <= S_DIV_4YR;
        S_DIV_4YR: if (status.div_fin) state <= S_TLOAD;
        S_TLOAD:   state <= S_DIV_YOE;
        S_DIV_YOE: if (status.div_fin) state <= S_YMUL;
        S_YMUL:    state <= S_FIN;
        S_DIFF, S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gregorian_date_offset_and_difference_top.sv =====
`timescale 1ns / 1ps

// Gregorian calendar unit: shifts a date by a signed day offset (func 0) or
// gives the signed day count and ordering between two dates (func 1).
// Input channel: an item is taken at a rising edge with start high and busy
// low; all input ports are sampled at that edge. busy stays high until the
// result is out.
// Output channel: done is high for exactly one cycle; the result ports are
// valid in that cycle and hold until the next item finishes. The receiver
// cannot stall, so there is no back-pressure: take the result when done is
// seen.
// Every date goes through a serial day number. All divisions are
// done by one shared divider that subtracts a constant once per cycle, so
// the time an item takes is set by its quotients. For a shift item most of
// that time goes into dividing the day of era by 365. One item is worked
// on at a time; a new item can be started in the cycle where done is high.
// Reset (rst, synchronous, active high) returns the controller to idle with
// busy and done low; no item in flight survives it. There is no clearing
// pass and nothing to configure.
module gregorian_date_offset_and_difference_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic                func,
  input  logic [13:0]         year,
  input  logic [3:0]          month,
  input  logic [4:0]          day,
  input  logic signed [20:0]  offset,
  input  logic [13:0]         other_year,
  input  logic [3:0]          other_month,
  input  logic [4:0]          other_day,
  output logic [13:0]         res_year,
  output logic [3:0]          res_month,
  output logic [4:0]          res_day,
  output logic signed [22:0]  day_difference,
  output logic [1:0]          ordering,
  output logic                invalid_date,
  output logic                year_overflow
);

  // Sequencer commands and datapath status
  gdod_pkg::cmd_t    cmd;
  gdod_pkg::status_t status;

  gdod_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  // Date clamp, serial conversion, shared divider and result registers
  gdod_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .func           (func),
    .year           (year),
    .month          (month),
    .day            (day),
    .offset         (offset),
    .other_year     (other_year),
    .other_month    (other_month),
    .other_day      (other_day),
    .res_year       (res_year),
    .res_month      (res_month),
    .res_day        (res_day),
    .day_difference (day_difference),
    .ordering       (ordering),
    .invalid_date   (invalid_date),
    .year_overflow  (year_overflow)
  );

endmodule
